// ----- rtl/artdmx_pkg.sv -----
// ============================================================================
// artdmx_pkg
// Shared types and constants for the ArtDMX pixel receiver.
// ============================================================================
package artdmx_pkg;

    // Input item commands
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Art-Net opcodes (little endian on the wire)
    localparam logic [15:0] OP_DMX  = 16'h5000;
    localparam logic [15:0] OP_POLL = 16'h2000;

    // Header layout
    localparam int unsigned HDR_LEN     = 18;
    localparam int unsigned MIN_ID_LEN  = 10;
    localparam int unsigned BYTE_CNT_W  = 10;
    localparam int unsigned STG_DEPTH   = 512;
    localparam int unsigned STG_AW      = 9;
    localparam int unsigned IDLE_W      = 17;

    // Register file
    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic        REG_TIMEOUT = 1'b0;
    localparam logic        REG_UNI_OFF = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [3:0] read_strip;
        logic [6:0] read_pixel;
    } t_in_item;

    typedef struct packed {
        logic       dmx_seen;
        logic       frame_committed;
        logic       poll_request;
        logic       active;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    // Events for the activity timer
    typedef struct packed {
        logic tick;
        logic refresh;
    } t_act_evt;

    // "Art-Net" followed by NUL
    function automatic logic [7:0] artnet_id_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            3'd7:    b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/artdmx_activity.sv -----
// ============================================================================
// artdmx_activity
// Idle timer and active flag: ArtDMX refreshes, millisecond ticks age it.
// ============================================================================
module artdmx_activity
    import artdmx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_act_evt    i_evt,
    input  logic [15:0] i_timeout_ms,
    output logic        o_active
);

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    logic [IDLE_W-1:0] r_idle;
    logic [IDLE_W-1:0] n_idle;
    logic              r_active;

    always_comb begin
        n_idle = (r_idle == IDLE_MAX) ? r_idle : r_idle + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle   <= '0;
            r_active <= 1'b0;
        end else if (i_evt.refresh) begin
            r_idle   <= '0;
            r_active <= 1'b1;
        end else if (i_evt.tick) begin
            r_idle <= n_idle;
            if (r_active && (n_idle > {1'b0, i_timeout_ms})) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_active = r_active;

`ifndef SYNTHESIS
    a_refresh_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.refresh |=> (r_active && (r_idle == '0)))
        else $error("refresh did not restart timer");

    a_idle_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.tick && !i_evt.refresh && (r_idle == IDLE_MAX)) |=> (r_idle == IDLE_MAX))
        else $error("idle timer wrapped");

    a_active_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_active) |-> $past(i_evt.refresh))
        else $error("active set without ArtDMX");
`endif

endmodule

// ----- rtl/artdmx_pixel_receiver.sv -----
// ============================================================================
// artdmx_pixel_receiver
// Art-Net ArtDMX receiver: header parse, DMX staging, commit to pixel store.
// ============================================================================
// Flow: byte, tick and pixel-read items pass ST_RESULT into the output
//   register; a packet-end byte first passes ST_FINISH, then ST_COMMIT when
//   pixels are copied (one staging memory read port, one byte per cycle).
// Acceptance: a new item is taken only once the last result is loaded.
// Reset: clearing pass writes zero through the pixel store, one entry per
//   cycle, all STRIPS*PIXELS_PER_STRIP entries (2048 by default); no item is
//   accepted meanwhile, configuration writes are taken as usual.
module artdmx_pixel_receiver
    import artdmx_pkg::*;
#(
    parameter int STRIPS           = 16,
    parameter int PIXELS_PER_STRIP = 128,
    parameter int MAX_PACKET_BYTES = 530
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    // APB-style config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int PIX_TOTAL = STRIPS * PIXELS_PER_STRIP;
    localparam int PIX_AW    = (PIX_TOTAL > 1) ? $clog2(PIX_TOTAL) : 1;
    localparam int PIX_IW    = $clog2(PIXELS_PER_STRIP + 1);
    localparam int SW        = (STRIPS > 1) ? $clog2(STRIPS) : 1;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0] r_state;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [15:0] r_timeout;
    logic [14:0] r_uni_off;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_uni_off <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TIMEOUT: r_timeout <= pwdata[15:0];
                REG_UNI_OFF: r_uni_off <= pwdata[14:0];
                default:     r_timeout <= r_timeout;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {16'b0, r_timeout};
            REG_UNI_OFF: prdata = {17'b0, r_uni_off};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat decode
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic                  is_byte;
    logic                  is_tick;
    logic                  is_read;
    logic                  byte_keep;
    logic                  stg_we;
    logic [STG_AW-1:0]     stg_waddr;
    logic                  rd_ok;
    logic [PIX_AW-1:0]     rd_addr;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_byte    = (i_in_item.cmd == CMD_BYTE);
    assign is_tick    = (i_in_item.cmd == CMD_TICK);
    assign is_read    = (i_in_item.cmd == CMD_READ);

    // Header byte registers
    logic [BYTE_CNT_W-1:0] r_byte_cnt;
    logic                  r_id_ok;
    logic [15:0]           r_opcode;
    logic [15:0]           r_universe;
    logic [15:0]           r_dmx_len;

    // bytes past the packet limit are dropped, count holds
    assign byte_keep = (32'(r_byte_cnt) < MAX_PACKET_BYTES);
    assign stg_we    = in_acc && is_byte && byte_keep && (32'(r_byte_cnt) >= HDR_LEN);
    assign stg_waddr = STG_AW'(r_byte_cnt - BYTE_CNT_W'(HDR_LEN));

    assign rd_ok   = (32'(i_in_item.read_strip) < STRIPS)
                  && (32'(i_in_item.read_pixel) < PIXELS_PER_STRIP);
    assign rd_addr = PIX_AW'(32'(i_in_item.read_strip) * PIXELS_PER_STRIP
                            + 32'(i_in_item.read_pixel));

    // ------------------------------------------------------------------
    // Packet-end evaluation (ST_FINISH)
    // ------------------------------------------------------------------
    logic        hdr_ok;
    logic        pkt_dmx;
    logic        pkt_poll;
    logic        uni_ge;
    logic [15:0] strip_diff;
    logic        strip_ok;
    logic        len_ok;
    logic        pkt_copy;
    logic        pkt_frame;
    logic [PIX_AW-1:0] strip_base;

    always_comb begin
        hdr_ok     = (32'(r_byte_cnt) >= MIN_ID_LEN) && r_id_ok;
        pkt_dmx    = hdr_ok && (r_opcode == OP_DMX) && (32'(r_byte_cnt) >= HDR_LEN);
        pkt_poll   = hdr_ok && (r_opcode == OP_POLL);
        uni_ge     = (r_universe >= {1'b0, r_uni_off});
        strip_diff = r_universe - {1'b0, r_uni_off};
        strip_ok   = (32'(strip_diff) < STRIPS);
        // declared DMX data must fit inside what was kept
        len_ok     = ({7'b0, r_byte_cnt} >= (17'(HDR_LEN) + {1'b0, r_dmx_len}));
        pkt_copy   = pkt_dmx && uni_ge && strip_ok && len_ok;
        // at least one full triple to copy
        pkt_frame  = pkt_copy && (r_dmx_len >= 16'd3);
        strip_base = PIX_AW'(32'(strip_diff[SW-1:0]) * PIXELS_PER_STRIP);
    end

    // ------------------------------------------------------------------
    // Activity timer
    // ------------------------------------------------------------------
    t_act_evt act_evt;
    logic     act_active;

    assign act_evt.tick    = in_acc && is_tick;
    assign act_evt.refresh = (r_state == ST_FINISH) && pkt_dmx;

    artdmx_activity u_activity (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (act_evt),
        .i_timeout_ms (r_timeout),
        .o_active     (act_active)
    );

    // ------------------------------------------------------------------
    // Commit copy engine state
    // ------------------------------------------------------------------
    logic [15:0]       r_cp_len;
    logic [PIX_AW-1:0] r_base;
    logic              r_iss;      // issuing staging reads
    logic [STG_AW-1:0] r_sa;       // staging read address
    logic [1:0]        r_iph;      // color phase of the issued read
    logic [PIX_IW-1:0] r_ipix;     // pixel of the issued read
    logic              r_dv;       // staging read data valid
    logic [1:0]        r_dph;
    logic [PIX_IW-1:0] r_dpix;
    logic [15:0]       r_acc;      // red, green gathered so far

    logic              pix_more;
    logic              stg_re;
    logic              cp_we;
    logic [PIX_AW-1:0] cp_waddr;

    // a pixel is started only when its whole triple lies inside the DMX length
    assign pix_more = (({8'b0, r_sa} + 17'd3) <= {1'b0, r_cp_len})
                   && (r_ipix < PIX_IW'(PIXELS_PER_STRIP));
    assign stg_re   = (r_state == ST_COMMIT) && r_iss && ((r_iph != 2'd0) || pix_more);
    assign cp_we    = (r_state == ST_COMMIT) && r_dv && (r_dph == 2'd2);
    assign cp_waddr = r_base + PIX_AW'(r_dpix);

    // ------------------------------------------------------------------
    // Staging memory: DMX data bytes of the current packet
    // ------------------------------------------------------------------
    logic [7:0] stg_mem [STG_DEPTH];
    logic [7:0] r_stg_q;

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            stg_mem[stg_waddr] <= i_in_item.data_byte;
        end
        if (stg_re) begin
            r_stg_q <= stg_mem[r_sa];
        end
    end

    // ------------------------------------------------------------------
    // Pixel memory: cleared after reset, written by commits
    // ------------------------------------------------------------------
    logic [23:0]       pix_mem [PIX_TOTAL];
    logic [23:0]       r_pix_q;
    logic [PIX_AW-1:0] r_clr_addr;
    logic              pix_we;
    logic [PIX_AW-1:0] pix_waddr;
    logic [23:0]       pix_wdata;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            pix_we    = 1'b1;
            pix_waddr = r_clr_addr;
            pix_wdata = '0;
        end else begin
            pix_we    = cp_we;
            pix_waddr = cp_waddr;
            pix_wdata = {r_acc, r_stg_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (in_acc && is_read && rd_ok) begin
            r_pix_q <= pix_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic        r_res_dmx;
    logic        r_res_frame;
    logic        r_res_poll;
    logic        r_res_rd;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        out_load;

    assign out_load = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_byte_cnt  <= '0;
            r_id_ok     <= 1'b1;
            r_opcode    <= '0;
            r_universe  <= '0;
            r_dmx_len   <= '0;
            r_iss       <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == PIX_AW'(PIX_TOTAL - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end

                ST_IDLE: begin
                    if (in_acc) begin
                        r_res_dmx   <= 1'b0;
                        r_res_frame <= 1'b0;
                        r_res_poll  <= 1'b0;
                        r_res_rd    <= is_read && rd_ok;
                        // end mark goes through packet-end evaluation
                        r_state     <= (is_byte && i_in_item.last_byte) ? ST_FINISH
                                                                         : ST_RESULT;
                        if (is_byte) begin
                            if (byte_keep) begin
                                r_byte_cnt <= r_byte_cnt + 1'b1;
                                if (r_byte_cnt < BYTE_CNT_W'(8)) begin
                                    if (i_in_item.data_byte !=
                                        artnet_id_byte(r_byte_cnt[2:0])) begin
                                        r_id_ok <= 1'b0;
                                    end
                                end else if (r_byte_cnt == BYTE_CNT_W'(8)) begin
                                    r_opcode[7:0] <= i_in_item.data_byte;
                                end else if (r_byte_cnt == BYTE_CNT_W'(9)) begin
                                    r_opcode[15:8] <= i_in_item.data_byte;
                                end else if (r_byte_cnt == BYTE_CNT_W'(14)) begin
                                    r_universe[7:0] <= i_in_item.data_byte;
                                end else if (r_byte_cnt == BYTE_CNT_W'(15)) begin
                                    r_universe[15:8] <= i_in_item.data_byte;
                                end else if (r_byte_cnt == BYTE_CNT_W'(16)) begin
                                    // DMX length is big endian
                                    r_dmx_len[15:8] <= i_in_item.data_byte;
                                end else if (r_byte_cnt == BYTE_CNT_W'(17)) begin
                                    r_dmx_len[7:0] <= i_in_item.data_byte;
                                end
                            end
                        end
                    end
                end

                ST_FINISH: begin
                    r_res_dmx   <= pkt_dmx;
                    r_res_frame <= pkt_frame;
                    r_res_poll  <= !pkt_dmx && pkt_poll;
                    r_cp_len    <= r_dmx_len;
                    r_base      <= strip_base;
                    r_sa        <= '0;
                    r_iph       <= '0;
                    r_ipix      <= '0;
                    r_dv        <= 1'b0;
                    r_iss       <= pkt_frame;
                    // ready for the next packet
                    r_byte_cnt  <= '0;
                    r_id_ok     <= 1'b1;
                    r_opcode    <= '0;
                    r_universe  <= '0;
                    r_dmx_len   <= '0;
                    r_state     <= pkt_frame ? ST_COMMIT : ST_RESULT;
                end

                ST_COMMIT: begin
                    // issue side
                    if (stg_re) begin
                        r_sa   <= r_sa + 1'b1;
                        r_dv   <= 1'b1;
                        r_dph  <= r_iph;
                        r_dpix <= r_ipix;
                        if (r_iph == 2'd2) begin
                            r_iph  <= 2'd0;
                            r_ipix <= r_ipix + 1'b1;
                        end else begin
                            r_iph <= r_iph + 1'b1;
                        end
                    end else begin
                        r_iss <= 1'b0;
                        r_dv  <= 1'b0;
                    end
                    // data side
                    if (r_dv) begin
                        r_acc <= {r_acc[7:0], r_stg_q};
                    end
                    if (!r_iss && !r_dv) begin
                        r_state <= ST_RESULT;
                    end
                end

                ST_RESULT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.dmx_seen        <= r_res_dmx;
            r_out.frame_committed <= r_res_frame;
            r_out.poll_request    <= r_res_poll;
            r_out.active          <= act_active;
            r_out.red             <= r_res_rd ? r_pix_q[23:16] : 8'd0;
            r_out.green           <= r_res_rd ? r_pix_q[15:8]  : 8'd0;
            r_out.blue            <= r_res_rd ? r_pix_q[7:0]   : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_frame_needs_dmx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.frame_committed || o_out_item.dmx_seen))
        else $error("frame committed without ArtDMX");

    a_commit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |=> ((r_state == ST_COMMIT) || (r_state == ST_RESULT)))
        else $error("commit left to wrong state");

    a_commit_pixel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cp_we |-> (32'(r_dpix) < PIXELS_PER_STRIP))
        else $error("commit pixel index out of strip");
`endif

endmodule
